// ===== rtl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Types and codes shared by the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

   typedef enum logic [1:0] {
      CMD_APPEND  = 2'd0,
      CMD_ALLOC   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2,
      STAT_RSVD = 2'd3
   } status_type;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   typedef struct packed {
      logic [15:0] base;
      logic [15:0] size;
      logic        used;
      logic [15:0] owner;
   } entry_type;

   // best candidate so far during a table scan
   typedef struct packed {
      logic      found;
      entry_type ent;
   } best_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_SPLIT_WR,
      ST_NEXT_RD,
      ST_NEXT_CHK,
      ST_MERGE_RD,
      ST_MERGE_WR,
      ST_FINAL_WR
   } state_type;

endpackage

// ===== rtl/pfa_pick.sv =====
// ----------------------------------------------------------------------------
// pfa_pick
// Compare unit of the table scan: decides whether an entry replaces the best.
// ----------------------------------------------------------------------------
module pfa_pick
   import pfa_pkg::*;
(
   input  logic        is_alloc,
   input  logic [1:0]  policy,
   input  logic [15:0] req_size,
   input  entry_type   ent,
   input  best_type    best,
   output logic        take
);

   logic fits;

   always_comb begin
      fits = !ent.used && (ent.size >= req_size);
      take = 1'b0;
      if (is_alloc) begin
         if (fits) begin
            priority if (!best.found)
               take = 1'b1;
            else if (policy == POL_BEST)
               take = ent.size <= best.ent.size;
            else if (policy == POL_WORST)
               take = ent.size >= best.ent.size;
            else
               take = 1'b0;
         end
      end else begin
         // release: smallest owner, lowest entry wins a tie
         take = ent.used && (!best.found || ent.owner < best.ent.owner);
      end
   end

endmodule

// ===== rtl/partition_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// partition_fit_allocator
// Address-ordered segment table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// Append and unknown commands: result strobe in the cycle after the start beat.
// Allocate and release scan the table through one registered read port, then
// decide, may shift entries up for a split or read the next entry and move
// entries down for a merge, and write the final entry. One item at a time;
// busy drops as the result strobe rises and the receiver never stalls it.
// Reset empties the table and sets first fit; no clearing pass is needed.
module partition_fit_allocator
   import pfa_pkg::*;
#(
   parameter int MAX_SEGMENTS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_process_id,
   input  logic [15:0] req_request_size,
   input  logic [15:0] req_segment_base,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_granted_address,
   output logic [15:0] rsp_granted_size,
   output logic [15:0] rsp_released_id,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

   entry_type   mem [MAX_SEGMENTS];
   entry_type   rdata_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic        wr_en;
   entry_type   wr_data;

   state_type   state_ff, state_in;
   logic [1:0]  policy_ff, policy_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] k_ff, k_in;
   logic        vld_ff, vld_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] best_pos_ff, best_pos_in;
   best_type    best_ff, best_in;
   logic        is_alloc_ff, is_alloc_in;
   logic [15:0] pid_ff, pid_in;
   logic [15:0] req_ff, req_in;
   entry_type   fin_ff, fin_in;
   logic        merge_ff, merge_in;
   logic        split_ff, split_in;
   logic        rv_ff, rv_in;
   status_type  st_ff, st_in;
   logic [15:0] addr_ff, addr_in, size_ff, size_in, id_ff, id_in;

   logic        take;
   logic [CW-1:0] pos1;
   logic [16:0] sum;

   pfa_pick u_pick (
      .is_alloc (is_alloc_ff),
      .policy   (policy_ff),
      .req_size (req_ff),
      .ent      (rdata_ff),
      .best     (best_ff),
      .take     (take)
   );

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rdata_ff <= mem[rd_addr];
   end

   assign pos1 = CW'(best_pos_ff) + CW'(1);
   assign sum  = {1'b0, best_ff.ent.size} + {1'b0, rdata_ff.size};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (cmd_type'(req_command) == CMD_ALLOC ||
                          cmd_type'(req_command) == CMD_RELEASE) && count_ff != '0)
               state_in = ST_SCAN;
         end
         ST_SCAN:
            if (idx_ff == count_ff && !vld_ff) state_in = ST_DECIDE;
         ST_DECIDE: begin
            priority if (!best_ff.found)
               state_in = ST_IDLE;
            else if (is_alloc_ff) begin
               if (best_ff.ent.size > req_ff && count_ff < MAX_CNT)
                  state_in = (count_ff > pos1) ? ST_SHIFT_RD : ST_SPLIT_WR;
               else
                  state_in = ST_FINAL_WR;
            end else
               state_in = (pos1 < count_ff) ? ST_NEXT_RD : ST_FINAL_WR;
         end
         ST_SHIFT_RD: state_in = ST_SHIFT_WR;
         ST_SHIFT_WR: state_in = (k_ff - CW'(1) > pos1) ? ST_SHIFT_RD : ST_SPLIT_WR;
         ST_SPLIT_WR: state_in = ST_FINAL_WR;
         ST_NEXT_RD:  state_in = ST_NEXT_CHK;
         ST_NEXT_CHK: begin
            if (!rdata_ff.used && pos1 + CW'(1) < count_ff)
               state_in = ST_MERGE_RD;
            else
               state_in = ST_FINAL_WR;
         end
         ST_MERGE_RD: state_in = ST_MERGE_WR;
         ST_MERGE_WR:
            state_in = (k_ff + CW'(2) < count_ff) ? ST_MERGE_RD : ST_FINAL_WR;
         ST_FINAL_WR: state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      policy_in   = policy_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      k_in        = k_ff;
      vld_in      = 1'b0;
      pos_in      = pos_ff;
      best_pos_in = best_pos_ff;
      best_in     = best_ff;
      is_alloc_in = is_alloc_ff;
      pid_in      = pid_ff;
      req_in      = req_ff;
      fin_in      = fin_ff;
      merge_in    = merge_ff;
      split_in    = split_ff;
      rv_in       = 1'b0;
      st_in       = st_ff;
      addr_in     = addr_ff;
      size_in     = size_ff;
      id_in       = id_ff;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = fin_ff;
      if (csr_valid && csr_ready)
         policy_in = csr_data;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pid_in      = req_process_id;
               req_in      = req_request_size;
               is_alloc_in = cmd_type'(req_command) == CMD_ALLOC;
               idx_in      = '0;
               best_in     = '0;
               best_pos_in = '0;
               merge_in    = 1'b0;
               split_in    = 1'b0;
               addr_in     = '0;
               size_in     = '0;
               id_in       = '0;
               unique case (cmd_type'(req_command))
                  CMD_APPEND: begin
                     rv_in = 1'b1;
                     if (count_ff >= MAX_CNT) begin
                        st_in = STAT_FULL;
                     end else begin
                        st_in   = STAT_DONE;
                        wr_en   = 1'b1;
                        wr_addr = count_ff[AW-1:0];
                        wr_data = '{base: req_segment_base, size: req_request_size,
                                    used: 1'b0, owner: 16'd0};
                        count_in = count_ff + CW'(1);
                        addr_in  = req_segment_base;
                        size_in  = req_request_size;
                     end
                  end
                  CMD_ALLOC, CMD_RELEASE: begin
                     if (count_ff == '0) begin
                        rv_in = 1'b1;
                        st_in = STAT_MISS;
                     end
                  end
                  default: begin
                     rv_in = 1'b1;
                     st_in = STAT_MISS;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue one read a cycle, judge each entry when it returns in the next cycle
            if (idx_ff != count_ff) begin
               rd_addr = idx_ff[AW-1:0];
               vld_in  = 1'b1;
               pos_in  = idx_ff[AW-1:0];
               idx_in  = idx_ff + CW'(1);
            end
            if (vld_ff && take) begin
               best_in     = '{found: 1'b1, ent: rdata_ff};
               best_pos_in = pos_ff;
            end
         end
         ST_DECIDE: begin
            k_in = count_ff;
            if (!best_ff.found) begin
               rv_in   = 1'b1;
               st_in   = STAT_MISS;
            end else if (is_alloc_ff) begin
               fin_in = '{base: best_ff.ent.base, size: best_ff.ent.size,
                          used: 1'b1, owner: pid_ff};
               if (best_ff.ent.size > req_ff && count_ff < MAX_CNT) begin
                  split_in    = 1'b1;
                  fin_in.size = req_ff;
               end
            end else begin
               fin_in      = best_ff.ent;
               fin_in.used = 1'b0;
            end
         end
         ST_SHIFT_RD: rd_addr = AW'(k_ff - CW'(1));
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[AW-1:0];
            wr_data = rdata_ff;
            k_in    = k_ff - CW'(1);
         end
         ST_SPLIT_WR: begin
            wr_en   = 1'b1;
            wr_addr = pos1[AW-1:0];
            wr_data = '{base: best_ff.ent.base + req_ff,
                        size: best_ff.ent.size - req_ff, used: 1'b0, owner: 16'd0};
         end
         ST_NEXT_RD: rd_addr = pos1[AW-1:0];
         ST_NEXT_CHK: begin
            k_in = pos1;
            if (!rdata_ff.used) begin
               merge_in    = 1'b1;
               fin_in.size = sum[16] ? 16'hFFFF : sum[15:0];
            end
         end
         ST_MERGE_RD: rd_addr = AW'(k_ff + CW'(1));
         ST_MERGE_WR: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[AW-1:0];
            wr_data = rdata_ff;
            k_in    = k_ff + CW'(1);
         end
         ST_FINAL_WR: begin
            wr_en   = 1'b1;
            wr_addr = best_pos_ff;
            wr_data = fin_ff;
            if (split_ff) count_in = count_ff + CW'(1);
            if (merge_ff) count_in = count_ff - CW'(1);
            rv_in   = 1'b1;
            st_in   = STAT_DONE;
            addr_in = fin_ff.base;
            size_in = fin_ff.size;
            id_in   = is_alloc_ff ? 16'd0 : fin_ff.owner;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         policy_ff <= POL_FIRST;
         count_ff  <= '0;
         vld_ff    <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         policy_ff <= policy_in;
         count_ff  <= count_in;
         vld_ff    <= vld_in;
         rv_ff     <= rv_in;
      end
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      best_pos_ff <= best_pos_in;
      best_ff     <= best_in;
      is_alloc_ff <= is_alloc_in;
      pid_ff      <= pid_in;
      req_ff      <= req_in;
      fin_ff      <= fin_in;
      merge_ff    <= merge_in;
      split_ff    <= split_in;
      st_ff       <= st_in;
      addr_ff     <= addr_in;
      size_ff     <= size_in;
      id_ff       <= id_in;
   end

   assign busy                = state_ff != ST_IDLE;
   assign csr_ready           = state_ff == ST_IDLE;
   assign rsp_valid           = rv_ff;
   assign rsp_status          = st_ff;
   assign rsp_granted_address = addr_ff;
   assign rsp_granted_size    = size_ff;
   assign rsp_released_id     = id_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("segment count beyond table depth");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_DONE |->
      rsp_granted_address == 16'd0 && rsp_granted_size == 16'd0 &&
      rsp_released_id == 16'd0) else $error("failed result carries data");
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> count_ff != '0) else $error("scan of empty table");
   a_final_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL_WR |=> rsp_valid && !busy) else $error("lost result");

endmodule
